>>> src/assert_macros.svh
// shared assertion macros for the scheduler checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside of reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> src/mlqs_pkg.sv
package mlqs_pkg;

   // request kinds carried in req_tuser
   localparam logic MODE_ENQ  = 1'b0;
   localparam logic MODE_DISP = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // request tdata layout
   localparam int REQ_ID_LSB  = 0;
   localparam int REQ_PRI_LSB = 8;
   localparam int REQ_TDATA_W = 16;

   // result tdata layout
   localparam int RSP_ST_LSB  = 0;
   localparam int RSP_ID_LSB  = 2;
   localparam int RSP_LV_LSB  = 10;
   localparam int RSP_TDATA_W = 16;

   // sequencer states
   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_INFO_RD = 7'b0000010,
      S_ENQ     = 7'b0000100,
      S_SCAN    = 7'b0001000,
      S_POP     = 7'b0010000,
      S_POP_RD  = 7'b0100000,
      S_OUT     = 7'b1000000
   } mlqs_state_type;

endpackage

>>> src/mlqs_ram.sv
module mlqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/multilevel_queue_slot_scheduler_top.sv
// Multilevel ready queue with one task-id FIFO per priority level (0 highest).
// An enqueue (req_tuser = 0) appends the id to its level, clamped to the
// lowest level, or answers status full. A dispatch (req_tuser = 1) serves the
// current level while it has slots left and holds tasks; otherwise it walks the
// levels upward from the current one, wrapping, takes the first that holds
// tasks and gives it NUM_PRIO-level-1 further slots. One item is in flight at a
// time and req_tready is low until its result is taken. A dispatch with nothing
// queued goes from idle straight to the result. An enqueue reads its level
// descriptor, then writes it and the task store unless the level is full. A
// dispatch reads the current level's descriptor, walks the levels if needed,
// one descriptor read per cycle, then pops, which costs one more read of the
// task store. The block is ready again the cycle after the result transfer.
module multilevel_queue_slot_scheduler_top #(
   parameter int NUM_PRIO    = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // task_id [7:0], priority_req [10:8], zero fill
   input  logic [mlqs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // mode [0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status [1:0], granted_id [9:2], granted_level [12:10], zero fill
   output logic [mlqs_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import mlqs_pkg::*;

   localparam int LW = $clog2(NUM_PRIO);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = $clog2(NUM_PRIO + 1);
   localparam int SD = NUM_PRIO * QUEUE_DEPTH;
   localparam int AW = $clog2(SD);
   localparam int TW = $clog2(SD + 1);
   localparam int IW = 2 * PW + CW;

   mlqs_state_type state_ff, state_in;

   logic [LW-1:0]     cur_ff, cur_in;
   logic [SW-1:0]     slots_ff, slots_in;
   logic [TW-1:0]     total_ff, total_in;
   logic [NUM_PRIO-1:0] lvl_vld_ff, lvl_vld_in;
   logic              is_enq_ff, is_enq_in;
   logic [LW-1:0]     lv_ff, lv_in;
   logic [7:0]        id_ff, id_in;
   logic [IW-1:0]     info_ff, info_in;
   logic [LW-1:0]     scan_lv_ff, scan_lv_in;
   logic [LW-1:0]     rd_lv_ff;
   logic              probe_ff, probe_in;
   logic              rd_ok_ff;
   logic [1:0]        st_ff, st_in;
   logic [7:0]        gid_ff, gid_in;
   logic [2:0]        glv_ff, glv_in;

   logic [LW-1:0]     info_raddr;
   logic [IW-1:0]     info_ram_q, info_q;
   logic              info_we;
   logic [IW-1:0]     info_wdata;
   logic              store_we;
   logic [AW-1:0]     store_waddr, store_raddr;
   logic [7:0]        store_q;

   logic              req_xfer, rsp_xfer;
   logic [2:0]        req_pri;
   logic [LW-1:0]     req_lv;
   logic [PW-1:0]     f_head, f_tail;
   logic [CW-1:0]     f_count, q_count;
   logic [PW-1:0]     head_nxt, tail_nxt;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // clamp the requested level to the lowest one
   assign req_pri = req_tdata[REQ_PRI_LSB +: 3];
   assign req_lv  = (8'(req_pri) >= 8'(NUM_PRIO)) ? LW'(NUM_PRIO - 1) : LW'(req_pri);

   // descriptor fields: captured copy and fresh read data
   assign f_head  = info_ff[PW-1:0];
   assign f_tail  = info_ff[2*PW-1:PW];
   assign f_count = info_ff[IW-1:2*PW];
   assign info_q  = rd_ok_ff ? info_ram_q : '0;
   assign q_count = info_q[IW-1:2*PW];

   // pointer advance with wrap
   assign head_nxt = (f_head == PW'(QUEUE_DEPTH - 1)) ? '0 : f_head + 1'b1;
   assign tail_nxt = (f_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : f_tail + 1'b1;

   // store addresses: level base plus slot pointer
   assign store_waddr = AW'(lv_ff) * AW'(QUEUE_DEPTH) + AW'(f_tail);
   assign store_raddr = AW'(lv_ff) * AW'(QUEUE_DEPTH) + AW'(f_head);

   // descriptor read address
   always_comb begin
      info_raddr = lv_ff;
      if (state_ff == S_IDLE) begin
         info_raddr = (req_tuser == MODE_ENQ) ? req_lv : cur_ff;
      end else if (state_ff == S_SCAN) begin
         info_raddr = scan_lv_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      slots_in   = slots_ff;
      total_in   = total_ff;
      lvl_vld_in = lvl_vld_ff;
      is_enq_in  = is_enq_ff;
      lv_in      = lv_ff;
      id_in      = id_ff;
      info_in    = info_ff;
      scan_lv_in = scan_lv_ff;
      probe_in   = 1'b0;
      st_in      = st_ff;
      gid_in     = gid_ff;
      glv_in     = glv_ff;
      info_we    = 1'b0;
      info_wdata = info_ff;
      store_we   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               is_enq_in = (req_tuser == MODE_ENQ);
               id_in     = req_tdata[REQ_ID_LSB +: 8];
               gid_in    = '0;
               glv_in    = '0;
               if (req_tuser == MODE_ENQ) begin
                  lv_in    = req_lv;
                  state_in = S_INFO_RD;
               end else if (total_ff == '0) begin
                  st_in    = ST_EMPTY;
                  state_in = S_OUT;
               end else begin
                  lv_in    = cur_ff;
                  state_in = S_INFO_RD;
               end
            end
         end
         S_INFO_RD: begin
            info_in = info_q;
            if (is_enq_ff) begin
               state_in = S_ENQ;
            end else if (slots_ff != '0 && q_count != '0) begin
               slots_in = slots_ff - 1'b1;
               state_in = S_POP;
            end else begin
               scan_lv_in = (cur_ff == LW'(NUM_PRIO - 1)) ? '0 : cur_ff + 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            // one descriptor probe per cycle, its read data checked in the next cycle
            if (probe_ff && q_count != '0) begin
               lv_in    = rd_lv_ff;
               cur_in   = rd_lv_ff;
               slots_in = SW'(NUM_PRIO - 1) - SW'(rd_lv_ff);
               info_in  = info_q;
               state_in = S_POP;
            end else begin
               scan_lv_in = (scan_lv_ff == LW'(NUM_PRIO - 1)) ? '0 : scan_lv_ff + 1'b1;
               probe_in   = 1'b1;
            end
         end
         S_ENQ: begin
            if (f_count == CW'(QUEUE_DEPTH)) begin
               st_in = ST_FULL;
            end else begin
               st_in             = ST_OK;
               store_we          = 1'b1;
               info_we           = 1'b1;
               info_wdata        = {f_count + 1'b1, tail_nxt, f_head};
               lvl_vld_in[lv_ff] = 1'b1;
               total_in          = total_ff + 1'b1;
            end
            state_in = S_OUT;
         end
         S_POP: begin
            info_we    = 1'b1;
            info_wdata = {f_count - 1'b1, f_tail, head_nxt};
            total_in   = total_ff - 1'b1;
            state_in   = S_POP_RD;
         end
         S_POP_RD: begin
            st_in    = ST_OK;
            gid_in   = store_q;
            glv_in   = 3'(lv_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_xfer) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cur_ff     <= '0;
         slots_ff   <= SW'(NUM_PRIO);
         total_ff   <= '0;
         lvl_vld_ff <= '0;
         probe_ff   <= 1'b0;
         rd_ok_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cur_ff     <= cur_in;
         slots_ff   <= slots_in;
         total_ff   <= total_in;
         lvl_vld_ff <= lvl_vld_in;
         probe_ff   <= probe_in;
         rd_ok_ff   <= lvl_vld_ff[info_raddr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      is_enq_ff  <= is_enq_in;
      lv_ff      <= lv_in;
      id_ff      <= id_in;
      info_ff    <= info_in;
      scan_lv_ff <= scan_lv_in;
      rd_lv_ff   <= scan_lv_ff;
      st_ff      <= st_in;
      gid_ff     <= gid_in;
      glv_ff     <= glv_in;
   end

   // per-level descriptors: head, tail, count
   mlqs_ram #(
      .WIDTH (IW),
      .DEPTH (NUM_PRIO)
   ) u_info_ram (
      .clock   (clock),
      .wr_en   (info_we),
      .wr_addr (lv_ff),
      .wr_data (info_wdata),
      .rd_addr (info_raddr),
      .rd_data (info_ram_q)
   );

   // task id store, one block of slots per level
   mlqs_ram #(
      .WIDTH (8),
      .DEPTH (SD)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (id_ff),
      .rd_addr (store_raddr),
      .rd_data (store_q)
   );

   // result transfer word
   always_comb begin
      rsp_tdata                    = '0;
      rsp_tdata[RSP_ST_LSB +: 2]   = st_ff;
      rsp_tdata[RSP_ID_LSB +: 8]   = gid_ff;
      rsp_tdata[RSP_LV_LSB +: 3]   = glv_ff;
   end

endmodule

>>> src/mlqs_checker.sv
`include "assert_macros.svh"

module mlqs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [mlqs_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mlqs_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import mlqs_pkg::*;

   logic       mode_ff;
   logic [1:0] st;
   logic [7:0] gid;
   logic [2:0] glv;
   logic       rsp_stall;
   logic       grant_void;
   logic       no_grant;
   logic       kind_ok;

   assign st  = rsp_tdata[RSP_ST_LSB +: 2];
   assign gid = rsp_tdata[RSP_ID_LSB +: 8];
   assign glv = rsp_tdata[RSP_LV_LSB +: 3];

   // result conditions
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign grant_void = (st != ST_OK) || (mode_ff == MODE_ENQ);
   assign no_grant   = (gid == 8'd0) && (glv == 3'd0);
   assign kind_ok    = (mode_ff == MODE_ENQ) ? (st == ST_OK || st == ST_FULL)
                                             : (st == ST_OK || st == ST_EMPTY);

   // kind of the last accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENQ;
      end else if (req_tvalid && req_tready) begin
         mode_ff <= req_tuser;
      end
   end

   // a stalled result holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata))

   // no new request while a result is pending
   `ASSERT_ALWAYS(a_one_in_flight, clock, rsp_tvalid |-> !req_tready)

   // failed or enqueue results carry no grant
   `ASSERT_CLK(a_zero_grant, clock, reset, rsp_tvalid && grant_void |-> no_grant)

   // status code matches the request kind
   `ASSERT_CLK(a_status_kind, clock, reset, rsp_tvalid |-> kind_ok)

endmodule

bind multilevel_queue_slot_scheduler_top mlqs_checker u_mlqs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import mlqs_pkg::*;

   localparam int NUM_PRIO     = 8;
   localparam int QUEUE_DEPTH  = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 300;
   localparam int DRAIN_CYCLES = NUM_PRIO + 8;

   // one scheduler answer, as carried on the result channel
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] id;
      logic [2:0] level;
   } grant_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = MODE_ENQ;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // ready-queue shadow state
   logic [7:0] lvl_store [NUM_PRIO][QUEUE_DEPTH];
   int         lvl_head [NUM_PRIO];
   int         lvl_tail [NUM_PRIO];
   int         lvl_count [NUM_PRIO];
   int         sched_level;
   int         sched_slots;

   grant_type  expected_grants [$];

   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         tready_hold_cycles = 0;
   int         tready_hold_left = 0;
   int         cycle_count = 0;
   int         fail_count = 0;
   int         transfers_checked = 0;
   int         grants_seen = 0;
   int         empties_seen = 0;
   int         fulls_seen = 0;

   multilevel_queue_slot_scheduler_top #(
      .NUM_PRIO    (NUM_PRIO),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // enqueue or weighted round-robin dispatch on the shadow state
   function automatic grant_type schedule_step(input logic mode, input logic [7:0] id,
                                               input logic [2:0] pri);
      grant_type g;
      int        lv;
      int        off;
      int        p;
      bit        has_task;
      g = '0;
      g.status = ST_OK;
      if (mode == MODE_ENQ) begin
         lv = (pri >= NUM_PRIO) ? NUM_PRIO - 1 : int'(pri);
         if (lvl_count[lv] >= QUEUE_DEPTH) begin
            g.status = ST_FULL;
            return g;
         end
         lvl_store[lv][lvl_tail[lv]] = id;
         lvl_tail[lv] = (lvl_tail[lv] + 1) % QUEUE_DEPTH;
         lvl_count[lv]++;
         return g;
      end

      has_task = 1'b0;
      for (lv = 0; lv < NUM_PRIO; lv++)
         if (lvl_count[lv] != 0) has_task = 1'b1;
      if (!has_task) begin
         g.status = ST_EMPTY;
         return g;
      end

      if (sched_level >= NUM_PRIO) sched_level = 0;
      // stay on the current level while it has slots and tasks, else walk upward
      if (sched_slots > 0 && lvl_count[sched_level] != 0) begin
         sched_slots--;
      end else begin
         lv = sched_level;
         for (off = 1; off < NUM_PRIO; off++) begin
            p = (sched_level + off) % NUM_PRIO;
            if (lvl_count[p] != 0) begin
               lv = p;
               break;
            end
         end
         sched_level = lv;
         sched_slots = NUM_PRIO - lv - 1;
      end

      g.id = lvl_store[sched_level][lvl_head[sched_level]];
      lvl_head[sched_level] = (lvl_head[sched_level] + 1) % QUEUE_DEPTH;
      lvl_count[sched_level]--;
      g.level = sched_level[2:0];
      return g;
   endfunction

   // offer one request, hold it until the transfer, then record its answer
   task automatic send_request(input logic mode, input logic [7:0] id,
                               input logic [2:0] pri);
      logic [REQ_TDATA_W-1:0] word;
      word = '0;
      word[REQ_ID_LSB +: 8] = id;
      word[REQ_PRI_LSB +: 3] = pri;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_grants.push_back(schedule_step(mode, id, pri));
   endtask

   // result side: random stalls, plus a counted hold-off on request
   always @(negedge clock) begin
      if (tready_hold_cycles > 0) begin
         tready_hold_left = tready_hold_cycles;
         tready_hold_cycles = 0;
      end
      if (tready_hold_left > 0) begin
         rsp_tready <= 1'b0;
         tready_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each result transfer with the oldest expected answer
   always @(posedge clock) begin : check_grants
      grant_type got;
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[RSP_ST_LSB +: 2];
         got.id = rsp_tdata[RSP_ID_LSB +: 8];
         got.level = rsp_tdata[RSP_LV_LSB +: 3];
         transfers_checked++;
         if (expected_grants.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result at cycle %0d: status %0d id %02h level %0d",
                        cycle_count, got.status, got.id, got.level);
         end else begin
            want = expected_grants.pop_front();
            case (want.status)
               ST_OK:    grants_seen++;
               ST_EMPTY: empties_seen++;
               default:  fulls_seen++;
            endcase
            if (got.status !== want.status || got.id !== want.id ||
                got.level !== want.level) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("cycle %0d: expected st %0d id %02h lv %0d, got st %0d id %02h lv %0d",
                           cycle_count, want.status, want.id, want.level,
                           got.status, got.id, got.level);
            end
         end
      end
   end

   // run-length guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers outstanding",
                  cycle_count, expected_grants.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // dispatch with nothing queued, ignored fields at their extremes
   task automatic test_empty_dispatch();
      send_request(MODE_DISP, 8'hFF, 3'd7);
   endtask

   // extreme ids and levels, level walk, reload of the only non-empty level
   task automatic test_extremes_and_reload();
      send_request(MODE_ENQ, 8'hFF, 3'd0);
      send_request(MODE_ENQ, 8'h00, 3'd7);
      send_request(MODE_ENQ, 8'h5A, 3'd7);
      send_request(MODE_DISP, 8'h00, 3'd0);
      send_request(MODE_DISP, 8'hA5, 3'd5);
      send_request(MODE_DISP, 8'h3C, 3'd2);
      send_request(MODE_DISP, 8'h00, 3'd0);
   endtask

   // one level filled past its depth, the last enqueue is rejected
   task automatic test_level_full();
      int n;
      for (n = 0; n <= QUEUE_DEPTH; n++)
         send_request(MODE_ENQ, 8'(8'h80 + n), 3'd4);
   endtask

   // bursts of enqueues and dispatches with varying mix and level focus
   task automatic run_mixed_traffic(input int item_total);
      int         sent;
      int         burst;
      int         enq_pct;
      int         hot_level;
      bit         focus;
      logic       mode;
      logic [2:0] pri;
      sent = 0;
      while (sent < item_total) begin
         burst = $urandom_range(40, 10);
         case ($urandom_range(3))
            0:       enq_pct = 25;
            1:       enq_pct = 50;
            2:       enq_pct = 75;
            default: enq_pct = 95;
         endcase
         hot_level = $urandom_range(NUM_PRIO - 1);
         focus = 1'($urandom_range(1));
         repeat (burst) begin
            mode = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DISP;
            pri = (focus && $urandom_range(3) != 0) ? 3'(hot_level) : 3'($urandom_range(7));
            send_request(mode, 8'($urandom_range(255)), pri);
            sent++;
         end
      end
   endtask

   task automatic test_no_idling();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_mixed_traffic(PHASE_ITEMS);
   endtask

   task automatic test_sender_idle();
      send_idle_pct = 66;
      recv_stall_pct = 0;
      run_mixed_traffic(PHASE_ITEMS);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct = 0;
      recv_stall_pct = 66;
      run_mixed_traffic(PHASE_ITEMS);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 7;
      recv_stall_pct = 7;
      run_mixed_traffic(PHASE_ITEMS);
   endtask

   // long result hold-off while requests keep coming, input must stall
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      tready_hold_cycles = HOLD_CYCLES;
      run_mixed_traffic(12);
   endtask

   initial begin : main_sequence
      int lv;
      for (lv = 0; lv < NUM_PRIO; lv++) begin
         lvl_head[lv] = 0;
         lvl_tail[lv] = 0;
         lvl_count[lv] = 0;
      end
      sched_level = 0;
      sched_slots = NUM_PRIO;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_empty_dispatch();
      test_extremes_and_reload();
      test_level_full();
      test_no_idling();
      test_sender_idle();
      test_output_hold_off();
      test_receiver_stall();
      test_both_idle();

      // stop offering, then let the last answers come out
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d transfers: %0d grants, %0d empty dispatches, %0d full rejects",
               transfers_checked, grants_seen, empties_seen, fulls_seen);
      $display("ran four idle mixes and a %0d-cycle result hold-off", HOLD_CYCLES);
      if (fail_count == 0 && expected_grants.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d failures", fail_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
